FILE: rtl/hfvc_pkg.sv
// ----------------------------------------------------------------------------
// hfvc_pkg
// Shared constants for the height fog vertex coordinate unit: register
// indexes, fixed widths of the scalar registers and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package hfvc_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_POSITION = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOG_UP_VECTOR   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_DIRECTION  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FOG_DENSITY     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_HEIGHT   = 3'd4;

    // Scalar register widths
    localparam int DENSITY_W    = 16;
    localparam int HEIGHT_W     = 20;
    // Q16.4 height moved to the Q.18 scale of depth
    localparam int HEIGHT_SHIFT = 14;

    localparam logic [DENSITY_W-1:0] DENSITY_RESET = 16'd655;

    // Q0.16 attenuation factor; one extra bit holds exactly 1.0
    localparam int FRAC_BITS = 16;
    localparam int F_W       = FRAC_BITS + 1;
    localparam logic [F_W-1:0] F_ONE = 17'h10000;

    // Rounding offset for the Q.32 -> Q.16 steps
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

endpackage

`default_nettype wire

FILE: rtl/hfvc_vertex_if.sv
// ----------------------------------------------------------------------------
// hfvc_vertex_if
// Vertex position channel: valid/ready handshake with x, y, z payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface hfvc_vertex_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] vertex_z;

    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/hfvc_fog_if.sv
// ----------------------------------------------------------------------------
// hfvc_fog_if
// Fog coordinate result channel: valid/ready handshake with coordinate and
// in-fog flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface hfvc_fog_if #(
    parameter int OUT_BITS = 32
);
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] fog_coord;
    logic                       in_fog;

    modport source (output valid, output fog_coord, output in_fog, input ready);
    modport sink   (input valid, input fog_coord, input in_fog, output ready);
endinterface

`default_nettype wire

FILE: rtl/hfvc_cfg_regs.sv
// ----------------------------------------------------------------------------
// hfvc_cfg_regs
// Configuration register file: camera position, fog plane up vector, view
// direction, fog density and camera height. Write-only port.
// ----------------------------------------------------------------------------
`default_nettype none

module hfvc_cfg_regs
    import hfvc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int VEC_W     = 3 * COORD_BITS,
    localparam int CFG_W     = (VEC_W > HEIGHT_W) ? VEC_W : HEIGHT_W
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    output logic [VEC_W-1:0]            camera_position,
    output logic [VEC_W-1:0]            fog_up_vector,
    output logic [VEC_W-1:0]            view_direction,
    output logic [DENSITY_W-1:0]        fog_density,
    output logic [HEIGHT_W-1:0]         camera_height
);

    logic [VEC_W-1:0]     cam_pos_reg;
    logic [VEC_W-1:0]     up_vec_reg;
    logic [VEC_W-1:0]     view_dir_reg;
    logic [DENSITY_W-1:0] density_reg;
    logic [HEIGHT_W-1:0]  height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_pos_reg  <= '0;
            up_vec_reg   <= '0;
            view_dir_reg <= '0;
            density_reg  <= DENSITY_RESET;
            height_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CAMERA_POSITION: cam_pos_reg  <= cfg_data[VEC_W-1:0];
                REG_FOG_UP_VECTOR:   up_vec_reg   <= cfg_data[VEC_W-1:0];
                REG_VIEW_DIRECTION:  view_dir_reg <= cfg_data[VEC_W-1:0];
                REG_FOG_DENSITY:     density_reg  <= cfg_data[DENSITY_W-1:0];
                REG_CAMERA_HEIGHT:   height_reg   <= cfg_data[HEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign camera_position = cam_pos_reg;
    assign fog_up_vector   = up_vec_reg;
    assign view_direction  = view_dir_reg;
    assign fog_density     = density_reg;
    assign camera_height   = height_reg;

endmodule

`default_nettype wire

FILE: rtl/hfvc_dot_pipe.sv
// ----------------------------------------------------------------------------
// hfvc_dot_pipe
// Three-stage front end: dist = camera - vertex, lane products against the
// up vector and the view direction, then the two dot-product sums.
// ----------------------------------------------------------------------------
`default_nettype none

module hfvc_dot_pipe
    import hfvc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int VEC_W     = 3 * COORD_BITS,
    localparam int DOT_W     = 2 * COORD_BITS + 3
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] vx,
    input  wire logic signed [COORD_BITS-1:0] vy,
    input  wire logic signed [COORD_BITS-1:0] vz,
    input  wire logic [VEC_W-1:0]             cam_pos,
    input  wire logic [VEC_W-1:0]             up_vec,
    input  wire logic [VEC_W-1:0]             view_dir,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [DOT_W-1:0]           depth,
    output logic signed [DOT_W-1:0]           dv
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] vert [3];
    logic signed [DIFF_W-1:0]     diff_next [3];
    logic signed [DIFF_W-1:0]     diff_reg [3];
    logic signed [PROD_W-1:0]     up_prod_next [3];
    logic signed [PROD_W-1:0]     up_prod_reg [3];
    logic signed [PROD_W-1:0]     view_prod_next [3];
    logic signed [PROD_W-1:0]     view_prod_reg [3];
    logic signed [DOT_W-1:0]      depth_next;
    logic signed [DOT_W-1:0]      dv_next;
    logic signed [DOT_W-1:0]      depth_reg;
    logic signed [DOT_W-1:0]      dv_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    logic                         v3_reg;
    logic                         adv1;
    logic                         adv2;
    logic                         adv3;

    assign vert[0] = vx;
    assign vert[1] = vy;
    assign vert[2] = vz;

    // A stage loads when it is empty or its content moves on
    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff_next[k] = DIFF_W'($signed(cam_pos[k*COORD_BITS +: COORD_BITS]))
                         - DIFF_W'(vert[k]);
            up_prod_next[k] = PROD_W'(diff_reg[k])
                            * PROD_W'($signed(up_vec[k*COORD_BITS +: COORD_BITS]));
            view_prod_next[k] = PROD_W'(diff_reg[k])
                              * PROD_W'($signed(view_dir[k*COORD_BITS +: COORD_BITS]));
        end
        depth_next = DOT_W'(up_prod_reg[0]) + DOT_W'(up_prod_reg[1])
                   + DOT_W'(up_prod_reg[2]);
        dv_next    = DOT_W'(view_prod_reg[0]) + DOT_W'(view_prod_reg[1])
                   + DOT_W'(view_prod_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
            diff_reg <= diff_next;
        if (adv2)
        begin
            up_prod_reg   <= up_prod_next;
            view_prod_reg <= view_prod_next;
        end
        if (adv3)
        begin
            depth_reg <= depth_next;
            dv_reg    <= dv_next;
        end
    end

    assign out_valid = v3_reg;
    assign depth     = depth_reg;
    assign dv        = dv_reg;

endmodule

`default_nettype wire

FILE: rtl/hfvc_frac_div.sv
// ----------------------------------------------------------------------------
// hfvc_frac_div
// Pipelined restoring divider for a proper fraction rem / den, one quotient
// bit per stage, FRAC_BITS stages. A sideband word travels with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module hfvc_frac_div
    import hfvc_pkg::*;
#(
    parameter int REM_W  = 35,
    parameter int SIDE_W = 54
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [REM_W-1:0]     in_rem,
    input  wire logic [REM_W-1:0]     in_den,
    input  wire logic [SIDE_W-1:0]    in_side,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [FRAC_BITS-1:0]      quot,
    output logic [SIDE_W-1:0]         out_side
);

    localparam int NSTAGE = FRAC_BITS;

    logic [REM_W-1:0]     rem_reg  [NSTAGE];
    logic [REM_W-1:0]     den_reg  [NSTAGE];
    logic [FRAC_BITS-1:0] q_reg    [NSTAGE];
    logic [SIDE_W-1:0]    side_reg [NSTAGE];
    logic [NSTAGE-1:0]    valid_reg;
    logic [NSTAGE:0]      adv;

    assign adv[NSTAGE] = out_ready;
    assign in_ready    = adv[0];

    for (genvar k = 0; k < NSTAGE; k++)
    begin : g_stage
        logic [REM_W-1:0]     rem_in;
        logic [REM_W-1:0]     den_in;
        logic [FRAC_BITS-1:0] q_in;
        logic [SIDE_W-1:0]    side_in;
        logic                 valid_in;
        logic [REM_W:0]       shifted;
        logic [REM_W:0]       reduced;
        logic                 ge;

        if (k == 0)
        begin : g_first
            assign rem_in   = in_rem;
            assign den_in   = in_den;
            assign q_in     = '0;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end
        else
        begin : g_next
            assign rem_in   = rem_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign q_in     = q_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        assign adv[k]  = !valid_reg[k] || adv[k+1];
        assign shifted = {rem_in, 1'b0};
        assign ge      = shifted >= {1'b0, den_in};
        assign reduced = ge ? (shifted - {1'b0, den_in}) : shifted;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (adv[k])
                valid_reg[k] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                // remainder stays below den, so the top bit is always zero
                rem_reg[k]  <= reduced[REM_W-1:0];
                den_reg[k]  <= den_in;
                q_reg[k]    <= {q_in[FRAC_BITS-2:0], ge};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[NSTAGE-1];
    assign quot      = q_reg[NSTAGE-1];
    assign out_side  = side_reg[NSTAGE-1];

endmodule

`default_nettype wire

FILE: rtl/height_fog_vertex_coord_unit.sv
// ----------------------------------------------------------------------------
// height_fog_vertex_coord_unit
// Layered height fog texture coordinate for one vertex position per cycle while fog.ready is high.
//
// Channels: vertex (sink) carries one object-space position per transaction;
// fog (source) returns one fog_coord / in_fog pair per vertex, in order.
// Configuration is a write-only port (cfg_wr_en, cfg_index, cfg_data); the user
// changes it only while no vertex is in flight; the block does not enforce this.
// Datapath: vertex acceptance feeds the dot-product stages (difference,
// lane products, sums), stage A for the fog test and density multiply,
// the pipelined divider (one quotient bit per stage) and stages C, D and
// E for attenuation multiply, rounding, saturation and the output register.
// Throughput: one vertex per cycle while fog.ready is high. Each stage
// keeps a valid bit and loads whenever it is empty or its content moves on,
// so bubbles are squeezed out and vertices keep entering while a finished
// result waits in the output register. When the receiver holds ready low
// the pipeline fills and then vertex.ready drops; nothing is lost or repeated.
// Reset: all valid bits clear; configuration registers return to their reset
// values (density 655, everything else zero).
// ----------------------------------------------------------------------------
`default_nettype none

module height_fog_vertex_coord_unit
    import hfvc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int OUT_BITS   = 32,
    localparam int VEC_W     = 3 * COORD_BITS,
    localparam int CFG_W     = (VEC_W > HEIGHT_W) ? VEC_W : HEIGHT_W
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    hfvc_vertex_if.sink                 vertex,
    hfvc_fog_if.source                  fog
);

    localparam int DOT_W  = 2 * COORD_BITS + 3;
    localparam int H_W    = HEIGHT_W + HEIGHT_SHIFT;
    localparam int CMP_W  = ((DOT_W > H_W) ? DOT_W : H_W) + 1;
    localparam int REM_W  = DOT_W;
    localparam int PD_W   = DOT_W + DENSITY_W + 1;
    localparam int SIDE_W = PD_W + 2;
    localparam int P_W    = PD_W - FRAC_BITS;
    localparam int MUL_W  = P_W + F_W + 1;
    localparam int R_W    = MUL_W - FRAC_BITS;
    localparam int SAT_W  = (R_W > OUT_BITS) ? R_W : OUT_BITS;

    localparam logic signed [SAT_W-1:0] SAT_HI =
        {{(SAT_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_LO =
        {{(SAT_W-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

    // configuration
    logic [VEC_W-1:0]     camera_position;
    logic [VEC_W-1:0]     fog_up_vector;
    logic [VEC_W-1:0]     view_direction;
    logic [DENSITY_W-1:0] fog_density;
    logic [HEIGHT_W-1:0]  camera_height;

    // dot product front end
    logic                    dot_valid;
    logic                    dot_ready;
    logic signed [DOT_W-1:0] depth;
    logic signed [DOT_W-1:0] dv;

    // stage A: fog test, division setup, density multiply
    logic signed [CMP_W-1:0] depth_ext;
    logic signed [CMP_W-1:0] h_ext;
    logic signed [CMP_W-1:0] depth_minus_h;
    logic signed [PD_W-1:0]  prod_next;
    logic                    fog_next;
    logic                    use_div_next;
    logic                    va_reg;
    logic                    adv_a;
    logic [REM_W-1:0]        rem_reg;
    logic [REM_W-1:0]        den_reg;
    logic signed [PD_W-1:0]  prod_reg;
    logic                    fog_a_reg;
    logic                    use_div_reg;

    // divider
    logic                    div_in_ready;
    logic                    div_valid;
    logic                    div_out_ready;
    logic [FRAC_BITS-1:0]    quot;
    logic [SIDE_W-1:0]       div_side;
    logic signed [PD_W-1:0]  div_prod;
    logic                    div_fog;
    logic                    div_use;

    // stage C: round P, pick factor
    logic signed [PD_W-1:0]  prod_rnd;
    logic                    vc_reg;
    logic                    adv_c;
    logic signed [P_W-1:0]   p_reg;
    logic [F_W-1:0]          f_reg;
    logic                    fog_c_reg;

    // stage D: attenuation multiply
    logic                    vd_reg;
    logic                    adv_d;
    logic signed [MUL_W-1:0] mul_next;
    logic signed [MUL_W-1:0] mul_reg;
    logic                    fog_d_reg;

    // stage E: round, saturate, output register
    logic signed [MUL_W-1:0] mul_rnd;
    logic signed [SAT_W-1:0] res_ext;
    logic signed [SAT_W-1:0] res_sat;
    logic                    adv_e;
    logic                    out_valid_reg;
    logic signed [OUT_BITS-1:0] fog_coord_reg;
    logic                    in_fog_reg;

    hfvc_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .camera_position (camera_position),
        .fog_up_vector   (fog_up_vector),
        .view_direction  (view_direction),
        .fog_density     (fog_density),
        .camera_height   (camera_height)
    );

    hfvc_dot_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_dot_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vertex.valid),
        .in_ready  (vertex.ready),
        .vx        (vertex.vertex_x),
        .vy        (vertex.vertex_y),
        .vz        (vertex.vertex_z),
        .cam_pos   (camera_position),
        .up_vec    (fog_up_vector),
        .view_dir  (view_direction),
        .out_valid (dot_valid),
        .out_ready (dot_ready),
        .depth     (depth),
        .dv        (dv)
    );

    // ---------------- stage A ----------------
    assign adv_a     = !va_reg || div_in_ready;
    assign dot_ready = adv_a;

    always_comb
    begin
        depth_ext     = CMP_W'(depth);
        h_ext         = CMP_W'($signed(camera_height)) <<< HEIGHT_SHIFT;
        depth_minus_h = depth_ext - h_ext;
        fog_next      = depth_ext >= h_ext;
        // divide only for a camera above the plane and a positive depth; otherwise the factor is 1
        use_div_next  = !camera_height[HEIGHT_W-1] && (camera_height != '0)
                      && (depth > DOT_W'(0));
        prod_next     = PD_W'(dv) * PD_W'($signed({1'b0, fog_density}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (adv_a)
            va_reg <= dot_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            rem_reg     <= depth_minus_h[REM_W-1:0];
            den_reg     <= depth[REM_W-1:0];
            prod_reg    <= prod_next;
            fog_a_reg   <= fog_next;
            use_div_reg <= use_div_next;
        end
    end

    // ---------------- divider ----------------
    hfvc_frac_div #(
        .REM_W  (REM_W),
        .SIDE_W (SIDE_W)
    ) u_frac_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (va_reg),
        .in_ready  (div_in_ready),
        .in_rem    (rem_reg),
        .in_den    (den_reg),
        .in_side   ({prod_reg, fog_a_reg, use_div_reg}),
        .out_valid (div_valid),
        .out_ready (div_out_ready),
        .quot      (quot),
        .out_side  (div_side)
    );

    assign div_prod = div_side[SIDE_W-1:2];
    assign div_fog  = div_side[1];
    assign div_use  = div_side[0];

    // ---------------- stage C ----------------
    assign adv_c         = !vc_reg || adv_d;
    assign div_out_ready = adv_c;
    assign prod_rnd      = div_prod + PD_W'(ROUND_HALF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (adv_c)
            vc_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv_c)
        begin
            p_reg     <= prod_rnd[PD_W-1:FRAC_BITS];
            f_reg     <= div_use ? {1'b0, quot} : F_ONE;
            fog_c_reg <= div_fog;
        end
    end

    // ---------------- stage D ----------------
    assign adv_d    = !vd_reg || adv_e;
    assign mul_next = MUL_W'(p_reg) * MUL_W'($signed({1'b0, f_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else if (adv_d)
            vd_reg <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_d)
        begin
            mul_reg   <= mul_next;
            fog_d_reg <= fog_c_reg;
        end
    end

    // ---------------- stage E ----------------
    assign adv_e = !out_valid_reg || fog.ready;

    always_comb
    begin
        mul_rnd = mul_reg + MUL_W'(ROUND_HALF);
        res_ext = SAT_W'($signed(mul_rnd[MUL_W-1:FRAC_BITS]));
        if (res_ext > SAT_HI)
            res_sat = SAT_HI;
        else if (res_ext < SAT_LO)
            res_sat = SAT_LO;
        else
            res_sat = res_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv_e)
            out_valid_reg <= vd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_e)
        begin
            fog_coord_reg <= fog_d_reg ? res_sat[OUT_BITS-1:0] : '0;
            in_fog_reg    <= fog_d_reg;
        end
    end

    assign fog.valid     = out_valid_reg;
    assign fog.fog_coord = fog_coord_reg;
    assign fog.in_fog    = in_fog_reg;

endmodule

`default_nettype wire
